// ===== design/acmw_pkg.sv =====
// Shared types, constants and helpers for the max-weight multi-pattern matcher.
package acmw_pkg;

    localparam int NODES    = 4096;
    localparam int NODE_W   = $clog2(NODES);
    localparam int CNT_W    = NODE_W + 1;
    localparam int ALPHABET = 26;
    localparam int SYM_W    = 5;
    localparam int PATTERNS = 256;
    localparam int ID_W     = 8;
    localparam int WGT_W    = 31;
    localparam int OP_W     = 3;

    typedef logic [NODE_W-1:0] node_t;
    typedef logic [ALPHABET-1:0][NODE_W-1:0] row_t;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR      = 3'd0,
        OP_PAT_SYM    = 3'd1,
        OP_END_PAT    = 3'd2,
        OP_BUILD      = 3'd3,
        OP_TEXT_SYM   = 3'd4,
        OP_END_TEXT   = 3'd5,
        OP_SET_WEIGHT = 3'd6
    } op_t;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_DISP, S_INS, S_SETW,
        S_SC_CHK, S_SC_X, S_SC_WALK,
        S_B_ROOT, S_B_DEQ, S_B_U1, S_B_U2, S_B_CH, S_B_FB, S_B_V
    } state_t;

    typedef enum logic [4:0] {
        A_NONE, A_LATCH, A_CLR_START, A_CLR_STEP, A_INS, A_END_PAT, A_END_TEXT,
        A_SET_W, A_SC_INIT, A_FB, A_SC_STEP, A_WALK, A_B_INIT, A_B_ROOT,
        A_B_DEQ, A_B_U2, A_B_SKIP, A_N_INIT_B, A_B_VSEL, A_B_LINK
    } act_t;

    typedef enum logic [2:0] {
        RD_ZERO, RD_CUR, RD_SCAN, RD_FL, RD_ENT, RD_Q, RD_UFL
    } rd_sel_t;

    typedef struct packed {
        act_t    act;
        rd_sel_t rd_sel;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic sym_ok;
        logic ent_zero;
        logic n_zero;
        logic x_zero;
        logic fl_zero;
        logic term;
        logic c_last;
        logic urow_zero;
        logic q_empty;
        logic clr_last;
    } stat_t;

    function automatic node_t row_entry(input row_t row, input logic [SYM_W-1:0] c);
        node_t r;
        r = '0;
        for (int i = 0; i < ALPHABET; i++) begin
            if (c == SYM_W'(i)) begin
                r = row[i];
            end
        end
        return r;
    endfunction

    function automatic row_t row_set(input row_t row, input logic [SYM_W-1:0] c,
                                     input node_t v);
        row_t r;
        r = row;
        for (int i = 0; i < ALPHABET; i++) begin
            if (c == SYM_W'(i)) begin
                r[i] = v;
            end
        end
        return r;
    endfunction

endpackage

// ===== design/aho_corasick_max_weight_matcher_top.sv =====
// Top level of the multi-pattern matcher reporting the largest matched weight.
// Usage: drive opcode, symbol, pattern_id and weight with start high; the item
// is taken at a clock edge where busy is low. Only an end-of-text item gives a
// result: done pulses for one cycle with max_weight and store_full valid,
// registered from the dispatch state that follows. Results cannot be held off.
// Steps per item, every step one read of the node memories: end pattern, end
// text and opcode 7 end with the dispatch step; a pattern symbol or set weight
// adds a write step. A text symbol follows failure links until a goto entry or
// the root, takes that entry and, when the new state is terminal, walks its
// suffix chain. Build scans the root row, then for each queued node reads its
// row and checks every symbol, following failure links and linking each child.
// Clear is a sweep of one node row per cycle over all 4096 nodes; after reset
// the same sweep runs with busy high before the first item is taken. The node
// memories have one read port, which sets the one-step-per-cycle pace of every
// walk.
module aho_corasick_max_weight_matcher_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [acmw_pkg::OP_W-1:0]      opcode,
    input  logic [acmw_pkg::SYM_W-1:0]     symbol,
    input  logic [acmw_pkg::ID_W-1:0]      pattern_id,
    input  logic [acmw_pkg::WGT_W-1:0]     weight,
    output logic                           done,
    output logic [acmw_pkg::WGT_W-1:0]     max_weight,
    output logic                           store_full
);
    import acmw_pkg::*;

    cmd_t  cmd;
    stat_t st;

    acmw_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .st    (st),
        .cmd   (cmd),
        .busy  (busy)
    );

    acmw_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .opcode     (opcode),
        .symbol     (symbol),
        .pattern_id (pattern_id),
        .weight     (weight),
        .st         (st),
        .done       (done),
        .max_weight (max_weight),
        .store_full (store_full)
    );

endmodule

// ===== design/acmw_ctrl.sv =====
// Sequencer for clear, insert, set-weight, build and scan operations.
module acmw_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  acmw_pkg::stat_t st,
    output acmw_pkg::cmd_t  cmd,
    output logic           busy
);
    import acmw_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_CLR;
        end
        else begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:     if (st.clr_last) state_next = S_IDLE;
            S_IDLE:    if (start) state_next = S_DISP;
            S_DISP:
            begin
                unique case (st.op)
                    OP_CLEAR:      state_next = S_CLR;
                    OP_PAT_SYM:    state_next = st.sym_ok ? S_INS : S_IDLE;
                    OP_BUILD:      state_next = S_B_ROOT;
                    OP_TEXT_SYM:   state_next = st.sym_ok ? S_SC_CHK : S_IDLE;
                    OP_SET_WEIGHT: state_next = S_SETW;
                    default:       state_next = S_IDLE;
                endcase
            end
            S_INS:     state_next = S_IDLE;
            S_SETW:    state_next = S_IDLE;
            S_SC_CHK:  if (st.n_zero || !st.ent_zero) state_next = S_SC_X;
            S_SC_X:
            begin
                if (st.x_zero || !st.term || st.fl_zero) state_next = S_IDLE;
                else state_next = S_SC_WALK;
            end
            S_SC_WALK: if (st.fl_zero) state_next = S_IDLE;
            S_B_ROOT:  if (st.c_last) state_next = S_B_DEQ;
            S_B_DEQ:   state_next = st.q_empty ? S_IDLE : S_B_U1;
            S_B_U1:    state_next = S_B_U2;
            S_B_U2:    state_next = S_B_CH;
            S_B_CH:
            begin
                if (!st.urow_zero) state_next = S_B_FB;
                else if (st.c_last) state_next = S_B_DEQ;
            end
            S_B_FB:    if (st.n_zero || !st.ent_zero) state_next = S_B_V;
            S_B_V:     state_next = st.c_last ? S_B_DEQ : S_B_CH;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.act    = A_NONE;
        cmd.rd_sel = RD_ZERO;
        busy       = 1'b1;
        unique case (state_reg)
            S_CLR:     cmd.act = A_CLR_STEP;
            S_IDLE:
            begin
                busy    = 1'b0;
                cmd.act = A_LATCH;
            end
            S_DISP:
            begin
                unique case (st.op)
                    OP_CLEAR:    cmd.act = A_CLR_START;
                    OP_PAT_SYM:  cmd.rd_sel = RD_CUR;
                    OP_END_PAT:  cmd.act = A_END_PAT;
                    OP_BUILD:    cmd.act = A_B_INIT;
                    OP_TEXT_SYM:
                    begin
                        cmd.act    = A_SC_INIT;
                        cmd.rd_sel = RD_SCAN;
                    end
                    OP_END_TEXT: cmd.act = A_END_TEXT;
                    default:     cmd.act = A_NONE;
                endcase
            end
            S_INS:     cmd.act = A_INS;
            S_SETW:    cmd.act = A_SET_W;
            S_SC_CHK, S_B_FB:
            begin
                cmd.rd_sel = (!st.n_zero && st.ent_zero) ? RD_FL : RD_ENT;
                if (!st.n_zero && st.ent_zero) cmd.act = A_FB;
                else cmd.act = (state_reg == S_SC_CHK) ? A_SC_STEP : A_B_VSEL;
            end
            S_SC_X:
            begin
                cmd.rd_sel = RD_FL;
                if (!st.x_zero && st.term) cmd.act = A_WALK;
            end
            S_SC_WALK:
            begin
                cmd.act    = A_WALK;
                cmd.rd_sel = RD_FL;
            end
            S_B_ROOT:  cmd.act = A_B_ROOT;
            S_B_DEQ:   if (!st.q_empty) cmd.act = A_B_DEQ;
            S_B_U1:    cmd.rd_sel = RD_Q;
            S_B_U2:    cmd.act = A_B_U2;
            S_B_CH:
            begin
                if (st.urow_zero) cmd.act = A_B_SKIP;
                else
                begin
                    cmd.act    = A_N_INIT_B;
                    cmd.rd_sel = RD_UFL;
                end
            end
            S_B_V:     cmd.act = A_B_LINK;
            default:   cmd.act = A_NONE;
        endcase
    end

endmodule

// ===== design/acmw_dpath.sv =====
// Trie memories, queue, cursors and running maximum.
module acmw_dpath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  acmw_pkg::cmd_t                 cmd,
    input  logic [acmw_pkg::OP_W-1:0]      opcode,
    input  logic [acmw_pkg::SYM_W-1:0]     symbol,
    input  logic [acmw_pkg::ID_W-1:0]      pattern_id,
    input  logic [acmw_pkg::WGT_W-1:0]     weight,
    output acmw_pkg::stat_t                st,
    output logic                           done,
    output logic [acmw_pkg::WGT_W-1:0]     max_weight,
    output logic                           store_full
);
    import acmw_pkg::*;

    // per-node memories read at one address; pattern-end and queue tables by id and head
    row_t              row_mem  [NODES];
    node_t             fl_mem   [NODES];
    logic              term_mem [NODES];
    logic [WGT_W-1:0]  wt_mem   [NODES];
    node_t             pen_mem  [PATTERNS];
    node_t             q_mem    [NODES];

    row_t              row_q;
    node_t             fl_q;
    logic              term_q;
    logic [WGT_W-1:0]  wt_q;
    node_t             pen_q;
    node_t             q_q;

    logic [CNT_W-1:0]  node_count_reg;
    node_t             ins_cur_reg;
    node_t             scan_reg;
    logic [WGT_W-1:0]  max_reg;
    logic              full_reg;
    node_t             head_reg;
    node_t             tail_reg;
    node_t             clr_cnt_reg;
    logic              done_reg;

    op_t               op_reg;
    logic [SYM_W-1:0]  c_reg;
    logic [ID_W-1:0]   id_reg;
    logic [WGT_W-1:0]  w_reg;
    node_t             n_reg;
    node_t             x_reg;
    node_t             v_reg;
    row_t              urow_reg;
    node_t             ufl_reg;
    logic [WGT_W-1:0]  max_weight_reg;
    logic              store_full_reg;

    node_t             rd_addr;
    node_t             ent;
    node_t             urow_ent;

    logic              row_we;
    node_t             row_wa;
    row_t              row_wd;
    logic              fl_we;
    node_t             fl_wa;
    node_t             fl_wd;
    logic              term_we;
    node_t             term_wa;
    logic              term_wd;
    logic              wt_we;
    node_t             wt_wa;
    logic [WGT_W-1:0]  wt_wd;
    logic              pen_we;
    logic              q_we;
    node_t             q_wd;

    assign ent      = row_entry(row_q, c_reg);
    assign urow_ent = row_entry(urow_reg, c_reg);

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_ZERO: rd_addr = '0;
            RD_CUR:  rd_addr = ins_cur_reg;
            RD_SCAN: rd_addr = scan_reg;
            RD_FL:   rd_addr = fl_q;
            RD_ENT:  rd_addr = ent;
            RD_Q:    rd_addr = q_q;
            RD_UFL:  rd_addr = ufl_reg;
            default: rd_addr = '0;
        endcase
    end

    always_comb
    begin
        row_we  = 1'b0;
        row_wa  = ins_cur_reg;
        row_wd  = row_set(row_q, c_reg, node_count_reg[NODE_W-1:0]);
        fl_we   = 1'b0;
        fl_wa   = x_reg;
        fl_wd   = v_reg;
        term_we = 1'b0;
        term_wa = x_reg;
        term_wd = 1'b1;
        wt_we   = 1'b0;
        wt_wa   = pen_q;
        wt_wd   = w_reg;
        pen_we  = 1'b0;
        q_we    = 1'b0;
        q_wd    = x_reg;
        unique case (cmd.act)
            A_CLR_STEP:
            begin
                row_we  = 1'b1;
                row_wa  = clr_cnt_reg;
                row_wd  = '0;
                fl_we   = 1'b1;
                fl_wa   = clr_cnt_reg;
                fl_wd   = '0;
                term_we = 1'b1;
                term_wa = clr_cnt_reg;
                term_wd = 1'b0;
                wt_we   = 1'b1;
                wt_wa   = clr_cnt_reg;
                wt_wd   = '0;
            end
            A_INS:     row_we = (ent == '0) && !node_count_reg[NODE_W];
            A_END_PAT:
            begin
                term_we = 1'b1;
                term_wa = ins_cur_reg;
                pen_we  = 1'b1;
            end
            A_SET_W:   wt_we = 1'b1;
            A_B_ROOT:
            begin
                fl_we = (ent != '0);
                fl_wa = ent;
                fl_wd = '0;
                q_we  = (ent != '0);
                q_wd  = ent;
            end
            A_B_LINK:
            begin
                fl_we   = 1'b1;
                term_we = term_q;   // terminal mark inherited from the link target
                q_we    = 1'b1;
            end
            default:   row_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (row_we) row_mem[row_wa] <= row_wd;
        if (fl_we) fl_mem[fl_wa] <= fl_wd;
        if (term_we) term_mem[term_wa] <= term_wd;
        if (wt_we) wt_mem[wt_wa] <= wt_wd;
        if (pen_we) pen_mem[id_reg] <= ins_cur_reg;
        if (q_we) q_mem[tail_reg] <= q_wd;
        row_q  <= row_mem[rd_addr];
        fl_q   <= fl_mem[rd_addr];
        term_q <= term_mem[rd_addr];
        wt_q   <= wt_mem[rd_addr];
        pen_q  <= pen_mem[id_reg];
        q_q    <= q_mem[head_reg];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            node_count_reg <= CNT_W'(1);
            ins_cur_reg    <= '0;
            scan_reg       <= '0;
            max_reg        <= '0;
            full_reg       <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            clr_cnt_reg    <= '0;
            done_reg       <= 1'b0;
        end
        else begin
            done_reg <= (cmd.act == A_END_TEXT);
            unique case (cmd.act)
                A_CLR_START:
                begin
                    node_count_reg <= CNT_W'(1);
                    ins_cur_reg    <= '0;
                    scan_reg       <= '0;
                    max_reg        <= '0;
                    full_reg       <= 1'b0;
                    clr_cnt_reg    <= '0;
                end
                A_CLR_STEP: clr_cnt_reg <= clr_cnt_reg + 1'b1;
                A_INS:
                begin
                    if (ent != '0) ins_cur_reg <= ent;
                    else if (node_count_reg[NODE_W]) full_reg <= 1'b1;
                    else
                    begin
                        ins_cur_reg    <= node_count_reg[NODE_W-1:0];
                        node_count_reg <= node_count_reg + 1'b1;
                    end
                end
                A_END_PAT:  ins_cur_reg <= '0;
                A_END_TEXT:
                begin
                    max_reg  <= '0;
                    scan_reg <= '0;
                end
                A_SC_STEP:  scan_reg <= ent;
                A_WALK:     if (term_q && (wt_q > max_reg)) max_reg <= wt_q;
                A_B_INIT:
                begin
                    head_reg <= '0;
                    tail_reg <= '0;
                end
                A_B_ROOT:   if (ent != '0) tail_reg <= tail_reg + 1'b1;
                A_B_DEQ:    head_reg <= head_reg + 1'b1;
                A_B_LINK:   tail_reg <= tail_reg + 1'b1;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.act)
            A_LATCH:
            begin
                op_reg <= op_t'(opcode);
                c_reg  <= symbol;
                id_reg <= pattern_id;
                w_reg  <= weight;
            end
            A_SC_INIT:  n_reg <= scan_reg;
            A_FB:       n_reg <= fl_q;
            A_SC_STEP:  x_reg <= ent;
            A_B_INIT:   c_reg <= '0;
            A_B_ROOT, A_B_SKIP, A_B_LINK: c_reg <= c_reg + 1'b1;
            A_B_U2:
            begin
                urow_reg <= row_q;
                ufl_reg  <= fl_q;
                c_reg    <= '0;
            end
            A_N_INIT_B:
            begin
                n_reg <= ufl_reg;
                x_reg <= urow_ent;
            end
            A_B_VSEL:   v_reg <= ent;
            A_END_TEXT:
            begin
                max_weight_reg <= max_reg;
                store_full_reg <= full_reg;
            end
            default:    v_reg <= v_reg;
        endcase
    end

    assign st.op        = op_reg;
    assign st.sym_ok    = (c_reg < SYM_W'(ALPHABET));
    assign st.ent_zero  = (ent == '0);
    assign st.n_zero    = (n_reg == '0);
    assign st.x_zero    = (x_reg == '0);
    assign st.fl_zero   = (fl_q == '0);
    assign st.term      = term_q;
    assign st.c_last    = (c_reg == SYM_W'(ALPHABET - 1));
    assign st.urow_zero = (urow_ent == '0);
    assign st.q_empty   = (head_reg == tail_reg);
    assign st.clr_last  = (clr_cnt_reg == node_t'(NODES - 1));

    assign done       = done_reg;
    assign max_weight = max_weight_reg;
    assign store_full = store_full_reg;

endmodule

// ===== tb/tb_aho_corasick_max_weight_matcher_top.sv =====
// Self-checking testbench for the max-weight multi-pattern matcher top level.
module tb_aho_corasick_max_weight_matcher_top;
    import acmw_pkg::*;

    localparam int              STALL_LIMIT = 1000000;
    localparam logic [OP_W-1:0] OP_NOP      = 3'd7;

    // Trie predictor plus the queue of end-of-text results it has produced.
    class match_scoreboard;
        node_t               goto_tbl[NODES][ALPHABET];
        node_t               fail_lnk[NODES];
        bit                  term[NODES];
        logic [WGT_W-1:0]    node_wgt[NODES];
        node_t               pat_node[PATTERNS];
        bit                  pat_known[PATTERNS];
        int                  node_cnt;
        node_t               ins_cur;
        node_t               scan_st;
        logic [WGT_W-1:0]    run_max;
        bit                  full;
        logic [WGT_W-1:0]    exp_max[$];
        bit                  exp_full[$];
        int                  errors;

        function new();
            errors = 0;
            foreach (pat_known[i]) pat_known[i] = 0;
            wipe();
        endfunction

        function void wipe();
            foreach (goto_tbl[n, c]) goto_tbl[n][c] = '0;
            foreach (fail_lnk[n]) begin
                fail_lnk[n] = '0;
                term[n]     = 0;
                node_wgt[n] = '0;
            end
            node_cnt = 1;
            ins_cur  = '0;
            scan_st  = '0;
            run_max  = '0;
            full     = 0;
        endfunction

        function node_t fall_back(node_t n, int c);
            int steps;
            steps = 0;
            while (n != 0 && goto_tbl[n][c] == 0 && steps < NODES) begin
                n = fail_lnk[n];
                steps++;
            end
            return n;
        endfunction

        function void build();
            node_t q[NODES];
            int    head;
            int    tail;
            node_t u;
            node_t x;
            node_t v;
            head = 0;
            tail = 0;
            for (int c = 0; c < ALPHABET; c++) begin
                x = goto_tbl[0][c];
                if (x != 0 && tail < NODES) begin
                    fail_lnk[x] = '0;
                    q[tail++] = x;
                end
            end
            while (head < tail) begin
                u = q[head++];
                for (int c = 0; c < ALPHABET; c++) begin
                    x = goto_tbl[u][c];
                    if (x != 0) begin
                        v = goto_tbl[fall_back(fail_lnk[u], c)][c];
                        fail_lnk[x] = v;
                        term[x] = term[x] | term[v];
                        if (tail < NODES) q[tail++] = x;
                    end
                end
            end
        endfunction

        function void note_item(logic [OP_W-1:0] op, logic [SYM_W-1:0] sym,
                                logic [ID_W-1:0] id, logic [WGT_W-1:0] w);
            node_t x;
            node_t k;
            int    steps;
            case (op)
                OP_CLEAR: wipe();
                OP_PAT_SYM:
                    if (sym < ALPHABET) begin
                        x = goto_tbl[ins_cur][sym];
                        if (x == 0) begin
                            if (node_cnt >= NODES) begin
                                full = 1;
                                return;
                            end
                            x = node_t'(node_cnt);
                            node_cnt++;
                            term[x] = 0;
                            goto_tbl[ins_cur][sym] = x;
                        end
                        ins_cur = x;
                    end
                OP_END_PAT: begin
                    term[ins_cur] = 1;
                    pat_node[id]  = ins_cur;
                    pat_known[id] = 1;
                    ins_cur = '0;
                end
                OP_BUILD: build();
                OP_TEXT_SYM:
                    if (sym < ALPHABET) begin
                        x = goto_tbl[fall_back(scan_st, sym)][sym];
                        scan_st = x;
                        if (term[x]) begin
                            k = x;
                            steps = 0;
                            while (k != 0 && steps < NODES) begin
                                if (term[k] && node_wgt[k] > run_max) run_max = node_wgt[k];
                                k = fail_lnk[k];
                                steps++;
                            end
                        end
                    end
                OP_END_TEXT: begin
                    exp_max  = {exp_max, run_max};
                    exp_full = {exp_full, full};
                    run_max = '0;
                    scan_st = '0;
                end
                OP_SET_WEIGHT: node_wgt[pat_node[id]] = w;
                default: ;
            endcase
        endfunction

        function void check(logic [WGT_W-1:0] mw, logic sf);
            logic [WGT_W-1:0] em;
            bit               ef;
            if (exp_max.size() == 0) begin
                $error("unexpected result max_weight=%0d store_full=%0d", mw, sf);
                errors++;
                return;
            end
            em = exp_max.pop_front();
            ef = exp_full.pop_front();
            if (mw !== em) begin
                $error("max_weight expected %0d actual %0d", em, mw);
                errors++;
            end
            if (sf !== ef) begin
                $error("store_full expected %0d actual %0d", ef, sf);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [OP_W-1:0]   opcode;
    logic [SYM_W-1:0]  symbol;
    logic [ID_W-1:0]   pattern_id;
    logic [WGT_W-1:0]  weight;
    logic              done;
    logic [WGT_W-1:0]  max_weight;
    logic              store_full;

    match_scoreboard sb;
    int  stall_cnt;
    bit  gaps_on;
    int  item_cnt;
    int  clear_cnt;

    aho_corasick_max_weight_matcher_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .symbol     (symbol),
        .pattern_id (pattern_id),
        .weight     (weight),
        .done       (done),
        .max_weight (max_weight),
        .store_full (store_full)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done) sb.check(max_weight, store_full);
            stall_cnt++;
            if (stall_cnt >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic push_item(logic [OP_W-1:0] op, logic [SYM_W-1:0] sym,
                             logic [ID_W-1:0] id, logic [WGT_W-1:0] w);
        if (gaps_on && $urandom_range(99) < 22)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        start      <= 1'b1;
        opcode     <= op;
        symbol     <= sym;
        pattern_id <= id;
        weight     <= w;
        do @(posedge clk); while (busy);
        sb.note_item(op, sym, id, w);
        stall_cnt = 0;
        item_cnt++;
        if (op == OP_CLEAR) clear_cnt++;
    endtask

    task automatic add_pattern(int len, int alpha, logic [ID_W-1:0] id);
        for (int i = 0; i < len; i++)
            push_item(OP_PAT_SYM, SYM_W'($urandom_range(alpha - 1)), ID_W'($urandom), WGT_W'($urandom));
        push_item(OP_END_PAT, SYM_W'($urandom), id, WGT_W'($urandom));
    endtask

    task automatic scan_text(int len, int alpha);
        for (int i = 0; i < len; i++)
            push_item(OP_TEXT_SYM, SYM_W'($urandom_range(alpha - 1)), ID_W'($urandom),
                      WGT_W'($urandom));
        push_item(OP_END_TEXT, SYM_W'($urandom), ID_W'($urandom), WGT_W'($urandom));
    endtask

    function automatic logic [WGT_W-1:0] rand_weight();
        case ($urandom_range(3))
            0: return '1;
            1: return WGT_W'($urandom_range(20));
            default: return WGT_W'($urandom);
        endcase
    endfunction

    task automatic random_weights(int n);
        logic [ID_W-1:0] id;
        for (int i = 0; i < n; i++)
        begin
            id = ID_W'($urandom);
            if (sb.pat_known[id]) push_item(OP_SET_WEIGHT, SYM_W'($urandom), id, rand_weight());
        end
    endtask

    initial
    begin
        int alpha;
        int npat;
        sb = new();
        stall_cnt = 0;
        gaps_on = 0;
        item_cnt = 0;
        clear_cnt = 0;
        rst_n = 0;
        start = 0;
        opcode = '0;
        symbol = '0;
        pattern_id = '0;
        weight = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: overlapping patterns, empty pattern, bad symbols, no-op
        push_item(OP_PAT_SYM, 5'd0, 8'd0, '0);
        push_item(OP_PAT_SYM, 5'd1, 8'd0, '0);
        push_item(OP_END_PAT, 5'd0, 8'd0, '0);
        push_item(OP_PAT_SYM, 5'd1, 8'd0, '0);
        push_item(OP_PAT_SYM, 5'd31, 8'd0, '0);
        push_item(OP_PAT_SYM, 5'd26, 8'd0, '0);
        push_item(OP_END_PAT, 5'd0, 8'd255, '0);
        push_item(OP_END_PAT, 5'd0, 8'd7, '0);
        push_item(OP_SET_WEIGHT, 5'd0, 8'd0, 31'h7FFFFFFF);
        push_item(OP_SET_WEIGHT, 5'd0, 8'd255, 31'd9);
        push_item(OP_SET_WEIGHT, 5'd0, 8'd7, 31'd1234);
        // scan before links are built
        push_item(OP_TEXT_SYM, 5'd1, 8'd0, '0);
        push_item(OP_END_TEXT, 5'd0, 8'd0, '0);
        push_item(OP_BUILD, 5'd0, 8'd0, '0);
        push_item(OP_NOP, 5'd31, 8'd255, 31'h7FFFFFFF);
        push_item(OP_TEXT_SYM, 5'd25, 8'd0, '0);
        push_item(OP_TEXT_SYM, 5'd31, 8'd0, '0);
        push_item(OP_TEXT_SYM, 5'd1, 8'd0, '0);
        push_item(OP_END_TEXT, 5'd0, 8'd0, '0);
        push_item(OP_TEXT_SYM, 5'd0, 8'd0, '0);
        push_item(OP_TEXT_SYM, 5'd1, 8'd0, '0);
        push_item(OP_END_TEXT, 5'd0, 8'd0, '0);
        push_item(OP_CLEAR, 5'd0, 8'd0, '0);
        push_item(OP_END_TEXT, 5'd0, 8'd0, '0);

        // random phases; the first few hundred items run without gaps
        while (item_cnt < 1300)
        begin
            gaps_on = (item_cnt > 300);
            if (clear_cnt < 25 && $urandom_range(3) == 0)
                push_item(OP_CLEAR, SYM_W'($urandom), ID_W'($urandom), WGT_W'($urandom));
            alpha = ($urandom_range(4) == 0) ? 32 : $urandom_range(2, 4);
            npat = $urandom_range(1, 8);
            for (int p = 0; p < npat; p++)
                add_pattern($urandom_range(0, 6), alpha, ID_W'($urandom));
            random_weights($urandom_range(2, 10));
            if ($urandom_range(9) != 0)
                push_item(OP_BUILD, SYM_W'($urandom), ID_W'($urandom), WGT_W'($urandom));
            for (int t = 0; t < $urandom_range(1, 4); t++)
            begin
                if ($urandom_range(9) == 0)
                    push_item(($urandom_range(9) < 5) ? OP_NOP :
                              OP_W'(OP_CLEAR + $urandom_range(6)),
                              SYM_W'($urandom), ID_W'($urandom), WGT_W'($urandom));
                if ($urandom_range(9) == 0) random_weights(1);
                scan_text($urandom_range(1, 20), alpha);
            end
        end

        // long patterns over the full alphabet, then build and scan
        push_item(OP_CLEAR, '0, '0, '0);
        for (int p = 0; p < 3; p++)
            add_pattern(40, ALPHABET, ID_W'($urandom));
        random_weights(20);
        push_item(OP_BUILD, '0, '0, '0);
        for (int t = 0; t < 3; t++)
            scan_text($urandom_range(20, 40), ALPHABET);
        start <= 1'b0;

        while (sb.exp_max.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
